>>> rtl/efra_pkg.sv
`timescale 1ns / 1ps

package efra_pkg;

  localparam int ROOMS  = 16;
  localparam int IDX_W  = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int CFG_W  = 5;
  localparam int IN_W   = 32;
  localparam int TIME_W = 40;
  localparam int BOOK_W = 32;
  localparam int ROOM_W = 4;

  localparam logic [CFG_W-1:0] ROOMS_RESET = CFG_W'(16);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [BOOK_W-1:0] book_t;

  // search word walking down the row of cells
  typedef struct packed {
    logic            valid;
    logic [IN_W-1:0] start;
    logic            found;
    idx_t            free_idx;
    time_t           min_at;
    idx_t            min_idx;
    book_t           max_cnt;
    idx_t            max_idx;
  } scan_t;

  // booking write broadcast to all cells
  typedef struct packed {
    logic  valid;
    idx_t  idx;
    time_t free_at;
  } wr_t;

endpackage

>>> rtl/efra_if.sv
`timescale 1ns / 1ps

interface efra_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_time;
  logic [31:0] end_time;
  modport source (output valid, output start_time, output end_time, input ready);
  modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

interface efra_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  assigned_room;
  logic [39:0] finish_time;
  logic [3:0]  most_booked_room;
  modport source (output valid, output assigned_room, output finish_time,
                  output most_booked_room, input ready);
  modport sink   (input valid, input assigned_room, input finish_time,
                  input most_booked_room, output ready);
endinterface

interface efra_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] rooms_in_use;
  modport source (output valid, output rooms_in_use, input ready);
  modport sink   (input valid, input rooms_in_use, output ready);
endinterface

>>> rtl/efra_cell.sv
`timescale 1ns / 1ps

module efra_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  efra_pkg::idx_t   idx,
  input  efra_pkg::cnt_t   count,
  input  efra_pkg::wr_t    wr,
  input  efra_pkg::scan_t  tok_in,
  output efra_pkg::scan_t  tok_out
);

  efra_pkg::time_t free_at_r;
  efra_pkg::book_t book_r;
  efra_pkg::scan_t tok_r;
  efra_pkg::scan_t tok_nxt;
  logic            act;

  assign act = {1'b0, idx} < count;

  always_comb begin
    tok_nxt = tok_in;
    if (act) begin
      if (!tok_in.found && free_at_r <= efra_pkg::TIME_W'(tok_in.start)) begin
        tok_nxt.found    = 1'b1;
        tok_nxt.free_idx = idx;
      end
      if (free_at_r < tok_in.min_at) begin
        tok_nxt.min_at  = free_at_r;
        tok_nxt.min_idx = idx;
      end
      if (book_r > tok_in.max_cnt) begin
        tok_nxt.max_cnt = book_r;
        tok_nxt.max_idx = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_at_r   <= '0;
      book_r      <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (wr.valid && wr.idx == idx) begin
        free_at_r <= wr.free_at;
        if (book_r != '1) begin
          book_r <= book_r + 1'b1;
        end
      end
    end
  end

  assign tok_out = tok_r;

endmodule

>>> rtl/earliest_free_room_allocator.sv
`timescale 1ns / 1ps

// Books each request word (start_time, end_time) into one of the first
// rooms_in_use rooms (0 reads as 1, more than ROOMS as ROOMS): the lowest
// free room, else the room that frees earliest, with the job delayed to keep
// its length. Each room is a cell in a row; a search word walks the row one
// cell a cycle, once to choose the room and once more, after the booking is
// written, to find the most-booked room. in_ch.ready stays low from
// acceptance until the result is loaded into the output register, so a new
// request is taken only after the last one is through. A finished result
// waits in the output register without holding up the next request; only if
// it is still waiting when the next result is ready does that request stall
// until out_ch takes the first.
// cfg_ch is always ready; write rooms_in_use only while no request is open.

module earliest_free_room_allocator (
  input  logic       clk,
  input  logic       rst_n,
  efra_req_if.sink   in_ch,
  efra_res_if.source out_ch,
  efra_cfg_if.sink   cfg_ch
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN1   = 6'b000010,
    S_UPD     = 6'b000100,
    S_LAUNCH2 = 6'b001000,
    S_SCAN2   = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

  state_t                        state_r;
  logic [efra_pkg::CFG_W-1:0]    rooms_r;
  efra_pkg::cnt_t                count;
  logic [efra_pkg::IN_W-1:0]     start_r;
  logic [efra_pkg::IN_W-1:0]     dur_r;
  efra_pkg::idx_t                pick_r;
  efra_pkg::time_t               finish_r;
  efra_pkg::idx_t                best_r;
  logic                          out_valid_r;
  logic [efra_pkg::ROOM_W-1:0]   out_room_r;
  logic [efra_pkg::TIME_W-1:0]   out_finish_r;
  logic [efra_pkg::ROOM_W-1:0]   out_best_r;

  efra_pkg::scan_t               chain [efra_pkg::ROOMS+1];
  efra_pkg::scan_t               last;
  efra_pkg::wr_t                 wr;
  logic                          in_fire;
  efra_pkg::idx_t                pick;
  efra_pkg::time_t               begin_at;
  logic [efra_pkg::TIME_W:0]     sum;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (rooms_r == '0) begin
      count = efra_pkg::CNT_W'(1);
    end else if (32'(rooms_r) > 32'(efra_pkg::ROOMS)) begin
      count = efra_pkg::CNT_W'(efra_pkg::ROOMS);
    end else begin
      count = efra_pkg::CNT_W'(rooms_r);
    end
  end

  // launch word: first pass on acceptance, second pass after the write
  always_comb begin
    chain[0].valid    = (in_fire || state_r == S_LAUNCH2);
    chain[0].start    = (state_r == S_IDLE) ? in_ch.start_time : start_r;
    chain[0].found    = 1'b0;
    chain[0].free_idx = '0;
    chain[0].min_at   = '1;
    chain[0].min_idx  = '0;
    chain[0].max_cnt  = '0;
    chain[0].max_idx  = '0;
  end

  assign wr.valid   = (state_r == S_UPD);
  assign wr.idx     = pick_r;
  assign wr.free_at = finish_r;

  for (genvar i = 0; i < efra_pkg::ROOMS; i++) begin : g_cell
    efra_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx     (efra_pkg::IDX_W'(i)),
      .count   (count),
      .wr      (wr),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign last = chain[efra_pkg::ROOMS];

  assign pick     = last.found ? last.free_idx : last.min_idx;
  assign begin_at = last.found ? efra_pkg::TIME_W'(start_r) : last.min_at;
  assign sum      = {1'b0, begin_at} + (efra_pkg::TIME_W+1)'(dur_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rooms_r     <= efra_pkg::ROOMS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        rooms_r <= cfg_ch.rooms_in_use;
      end
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            start_r <= in_ch.start_time;
            dur_r   <= (in_ch.end_time > in_ch.start_time) ?
                       in_ch.end_time - in_ch.start_time : '0;
            state_r <= S_SCAN1;
          end
        end
        S_SCAN1: begin
          if (last.valid) begin
            pick_r   <= pick;
            finish_r <= sum[efra_pkg::TIME_W] ? '1 : sum[efra_pkg::TIME_W-1:0];
            state_r  <= S_UPD;
          end
        end
        S_UPD: begin
          state_r <= S_LAUNCH2;
        end
        S_LAUNCH2: begin
          state_r <= S_SCAN2;
        end
        S_SCAN2: begin
          if (last.valid) begin
            best_r  <= last.max_idx;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_room_r   <= efra_pkg::ROOM_W'(pick_r);
            out_finish_r <= finish_r;
            out_best_r   <= efra_pkg::ROOM_W'(best_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.assigned_room    = out_room_r;
  assign out_ch.finish_time      = out_finish_r;
  assign out_ch.most_booked_room = out_best_r;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [3:0]      room;
    efra_pkg::time_t finish;
    logic [3:0]      top;
  } booking_t;

  logic clk;
  logic rst_n;

  efra_req_if req_ch ();
  efra_res_if res_ch ();
  efra_cfg_if cfg_ch ();

  earliest_free_room_allocator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  efra_pkg::time_t room_free [efra_pkg::ROOMS];
  efra_pkg::book_t room_books [efra_pkg::ROOMS];
  logic [4:0]      rooms_cfg;
  booking_t        pending_bookings [$];
  logic [31:0]     clock_now;

  bit tx_idle;
  bit rx_idle;
  int long_hold;
  int jobs_sent;
  int results_checked;
  int mismatches;
  int room_writes;
  bit finish_capped;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("[earliest_free_room_allocator] ERROR");
    $finish;
  end

  // expected booking for one request word; updates the shadow room state
  function automatic booking_t book_job(input logic [31:0] s, input logic [31:0] e);
    booking_t                  r;
    int                        n;
    int                        pick;
    int                        best;
    bit                        found;
    efra_pkg::time_t           t_start;
    logic [31:0]               dur;
    logic [efra_pkg::TIME_W:0] sum;
    n = (rooms_cfg == 0) ? 1 :
        (rooms_cfg > efra_pkg::ROOMS) ? efra_pkg::ROOMS : int'(rooms_cfg);
    dur = (e > s) ? e - s : '0;
    pick = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && room_free[i] <= efra_pkg::TIME_W'(s)) begin
        pick = i;
        found = 1'b1;
      end
    end
    if (found) begin
      t_start = efra_pkg::TIME_W'(s);
    end else begin
      for (int i = 1; i < n; i++) begin
        if (room_free[i] < room_free[pick]) pick = i;
      end
      t_start = room_free[pick];
    end
    sum = {1'b0, t_start} + (efra_pkg::TIME_W + 1)'(dur);
    r.finish = sum[efra_pkg::TIME_W] ? '1 : sum[efra_pkg::TIME_W-1:0];
    if (r.finish == '1) finish_capped = 1'b1;
    room_free[pick] = r.finish;
    if (room_books[pick] != '1) room_books[pick]++;
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (room_books[i] > room_books[best]) best = i;
    end
    r.room = 4'(pick);
    r.top  = 4'(best);
    return r;
  endfunction

  task automatic send_job(input logic [31:0] s, input logic [31:0] e);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.start_time <= s;
    req_ch.end_time   <= e;
    do @(posedge clk); while (!req_ch.ready);
    pending_bookings.push_back(book_job(s, e));
    jobs_sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_bookings.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_rooms(input logic [4:0] n);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.rooms_in_use <= n;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    rooms_cfg = n;
    room_writes++;
  endtask

  // mostly ordered requests with random content, plus some malformed words
  task automatic send_burst(input int n);
    logic [31:0] s;
    logic [31:0] e;
    logic [31:0] dur;
    int          kind;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        if ($urandom_range(0, 19) == 0) clock_now += $urandom_range(0, 32'h0FFF_FFFF);
        else clock_now += $urandom_range(0, 40);
        s = clock_now;
        dur = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 300);
        e = s + dur;
      end else if (kind < 88) begin
        s = clock_now;
        e = s - $urandom_range(0, 10);
      end else if (kind < 94) begin
        s = clock_now - $urandom_range(1, 500);
        e = s + $urandom_range(1, 300);
      end else begin
        s = $urandom;
        e = $urandom;
      end
      send_job(s, e);
    end
  endtask

  task automatic test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_job(32'd0, 32'd0);
    send_job(32'd0, 32'd1);
    send_job(32'd0, 32'hFFFF_FFFF);
    send_job(32'd5, 32'd3);
    for (int i = 0; i < 16; i++) send_job(32'd10, 32'd20);
    send_job(32'd3, 32'd50);
    send_job(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_room_counts();
    logic [4:0] sizes [8] = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd16, 5'd2, 5'd8, 5'd15};
    clock_now = 32'd1000;
    for (int p = 0; p < 8; p++) begin
      write_rooms(sizes[p]);
      send_burst(10);
      drain();
    end
  endtask

  task automatic test_backpressure();
    write_rooms(5'd4);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    long_hold = 400;
    send_burst(25);
    drain();
  endtask

  task automatic test_random();
    logic [4:0] n;
    for (int p = 0; p < 12; p++) begin
      n = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
      write_rooms(n);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      send_burst(130);
      drain();
    end
  endtask

  // one room, longest jobs: the delays pile up until the finish time caps
  task automatic test_time_cap();
    write_rooms(5'd1);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < 270; i++) send_job(32'd0, 32'hFFFF_FFFF);
    drain();
    write_rooms(5'd2);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_burst(10);
    drain();
  endtask

  initial begin
    rst_n               <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.start_time   <= '0;
    req_ch.end_time     <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.rooms_in_use <= '0;
    for (int i = 0; i < efra_pkg::ROOMS; i++) begin
      room_free[i]  = '0;
      room_books[i] = '0;
    end
    rooms_cfg = efra_pkg::ROOMS_RESET;
    clock_now = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_room_counts();
    test_backpressure();
    test_random();
    test_time_cap();

    repeat (2 * efra_pkg::ROOMS + 8) @(posedge clk);
    if (pending_bookings.size() != 0) begin
      $display("%0d expected words never arrived", pending_bookings.size());
      mismatches += pending_bookings.size();
    end
    $display("covered %0d requests, %0d results checked, %0d room-count writes",
             jobs_sent, results_checked, room_writes);
    $display("room counts incl. out-of-range, long output stall, finish-time cap %s",
             finish_capped ? "reached" : "not reached");
    if (mismatches == 0) begin
      $display("[earliest_free_room_allocator] OK");
    end else begin
      $display("[earliest_free_room_allocator] ERROR");
    end
    $finish;
  end

  initial begin
    int w;
    res_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold > 0) begin
        w = long_hold;
        long_hold = 0;
      end else begin
        w = rx_idle ? $urandom_range(0, 17) : 0;
      end
      if (w > 0) begin
        res_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  always @(posedge clk) begin
    booking_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_bookings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: room %0d finish %h top %0d", res_ch.assigned_room,
                   res_ch.finish_time, res_ch.most_booked_room);
      end else begin
        want = pending_bookings.pop_front();
        results_checked++;
        if (res_ch.assigned_room !== want.room || res_ch.finish_time !== want.finish ||
            res_ch.most_booked_room !== want.top) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: room exp %0d got %0d, finish exp %h got %h, top exp %0d got %0d",
                     want.room, res_ch.assigned_room, want.finish, res_ch.finish_time,
                     want.top, res_ch.most_booked_room);
        end
      end
    end
  end

endmodule

>>> filelist.f
rtl/efra_pkg.sv
rtl/efra_if.sv
rtl/efra_cell.sv
rtl/earliest_free_room_allocator.sv
sim/tb.sv
